/* rtl/prn_bpsk_and_multitone_iq_generator_unit_defines.svh */
// Assertion macros for the generator's RTL files.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef PRN_BPSK_AND_MULTITONE_IQ_GENERATOR_UNIT_DEFINES_SVH
`define PRN_BPSK_AND_MULTITONE_IQ_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBMIG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pbmig check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PBMIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbmig check failed in the following cycle");

`endif

/* rtl/pbmig_pkg.sv */
// Package of the PRN BPSK and multi-tone I/Q generator: widths, register map,
// controller/datapath link types and the sine table arithmetic. No dependencies.
package pbmig_pkg;

	localparam int unsigned CHANNELS_DEF   = 4;
	localparam int unsigned TABLE_BITS_DEF = 10;
	localparam int unsigned STEP_REGS      = 4;
	localparam int unsigned PADDR_W        = 6;
	localparam int unsigned PDATA_W        = 64;
	localparam int unsigned PHASE_W        = 32;
	localparam int unsigned OFFSET_W       = 16;
	localparam int unsigned MASK_W         = 4;
	localparam int unsigned AMP_W          = 15;
	localparam int unsigned SAMPLE_W       = 17;
	localparam int unsigned ACC_W          = 20;
	localparam int unsigned LFSR_W         = 16;
	localparam int unsigned REG_IDX_W      = 3;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [ACC_W-1:0] SAT_HI = 20'sd32768;
	localparam logic signed [ACC_W-1:0] SAT_LO = -20'sd32768;

	typedef logic [PHASE_W-1:0] phase_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CARRIER_STEP = 3'd0,
		REG_VISIBLE_MASK = 3'd1,
		REG_DOPPLER_0    = 3'd2,
		REG_DOPPLER_1    = 3'd3,
		REG_DOPPLER_2    = 3'd4,
		REG_DOPPLER_3    = 3'd5,
		REG_OFFSET_WORDS = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic last_ch;
		logic out_free;
	} dp_status_t;

	// Rounded quarter-wave sine magnitude in Q14, evaluated at elaboration.
	function automatic logic [AMP_W-1:0] quarter_sine(input int unsigned m,
		input int unsigned tb);
		logic [63:0] x;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] t;
		logic [63:0] s;
		x  = 64'(m) << (30 - tb);
		a  = (x * HALF_PI_Q30) >> 30;
		a2 = (a * a) >> 30;
		t  = ONE_Q30 - a2 / 64'd110;
		t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd72;
		t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd6;
		s  = (a * t) >> 30;
		s  = (s + 64'd32768) >> 16;
		if (s > 64'd16384) begin
			s = 64'd16384;
		end
		return s[AMP_W-1:0];
	endfunction

	// Halves a composite sum, rounding half up, and saturates to Q3.14.
	function automatic logic [SAMPLE_W-1:0] halve_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] sum;
		logic signed [ACC_W-1:0] h;
		sum = acc + $signed(ACC_W'(1));
		h   = sum >>> 1;
		if (h > SAT_HI) begin
			h = SAT_HI;
		end
		if (h < SAT_LO) begin
			h = SAT_LO;
		end
		return h[SAMPLE_W-1:0];
	endfunction

endpackage

/* rtl/pbmig_if.sv */
// Valid/ready channel interfaces for sample ticks and I/Q samples.
// Depends on pbmig_pkg for the sample width.
interface pbmig_tick_if;
	logic valid;
	logic ready;
	logic restart;
	logic final_tick;

	modport source (output valid, output restart, output final_tick, input ready);
	modport sink (input valid, input restart, input final_tick, output ready);
endinterface

interface pbmig_sample_if
	import pbmig_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] i_sample;
	logic signed [SAMPLE_W-1:0] q_sample;
	logic                       last;

	modport source (output valid, output i_sample, output q_sample, output last, input ready);
	modport sink (input valid, input i_sample, input q_sample, input last, output ready);
endinterface

/* rtl/prn_bpsk_and_multitone_iq_generator_unit.sv */
// Each accepted tick yields one I/Q sample: with no visible channel, an LFSR chip
// times cos/sin of the carrier phase; otherwise half the sum of cos/sin over the
// visible channels. For each tick the block walks the channels in turn through the
// shared dual-read sine table, then settles the accumulation and finishes. The
// sample waits in an output register, and the next tick is taken while it waits.
// Depends on pbmig_pkg, pbmig_if, pbmig_cfg, pbmig_ctrl, pbmig_dpath and pbmig_rom.
module prn_bpsk_and_multitone_iq_generator_unit
	import pbmig_pkg::*;
#(
	parameter int unsigned CHANNELS   = CHANNELS_DEF,
	parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pbmig_tick_if.sink           tick,
	pbmig_sample_if.source       sample,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	phase_t             carrier_step;
	logic [MASK_W-1:0]  visible_mask;
	phase_t             doppler_step [STEP_REGS];
	logic [PDATA_W-1:0] offset_words;
	dp_cmd_t            cmd;
	dp_status_t         status;

	pbmig_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.carrier_step (carrier_step),
		.visible_mask (visible_mask),
		.doppler_step (doppler_step),
		.offset_words (offset_words)
	);

	pbmig_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pbmig_dpath #(
		.CHANNELS   (CHANNELS),
		.TABLE_BITS (TABLE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.restart      (tick.restart),
		.final_tick   (tick.final_tick),
		.carrier_step (carrier_step),
		.visible_mask (visible_mask),
		.doppler_step (doppler_step),
		.offset_words (offset_words),
		.out_valid    (sample.valid),
		.out_ready    (sample.ready),
		.i_sample     (sample.i_sample),
		.q_sample     (sample.q_sample),
		.last         (sample.last)
	);

endmodule

/* rtl/pbmig_rom.sv */
// Dual-read quarter-wave sine table with registered read data.
// Depends on pbmig_pkg for the table arithmetic; contents are fixed at elaboration.
module pbmig_rom
	import pbmig_pkg::*;
#(
	parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic [TABLE_BITS:0]   addr_a,
	input  logic [TABLE_BITS:0]   addr_b,
	output logic [AMP_W-1:0]      data_a,
	output logic [AMP_W-1:0]      data_b
);

	localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

	typedef logic [AMP_W-1:0] rom_arr_t [DEPTH];

	function automatic rom_arr_t build_rom();
		rom_arr_t r;
		for (int unsigned i = 0; i < DEPTH; i++) begin
			r[i] = quarter_sine(i, TABLE_BITS);
		end
		return r;
	endfunction

	localparam rom_arr_t ROM = build_rom();

	logic [AMP_W-1:0] rd_a_q;
	logic [AMP_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		rd_a_q <= ROM[addr_a];
		rd_b_q <= ROM[addr_b];
	end

	assign data_a = rd_a_q;
	assign data_b = rd_b_q;

endmodule

/* rtl/pbmig_cfg.sv */
// APB-style configuration register bank of the generator.
// Depends on pbmig_pkg for the register map and widths.
module pbmig_cfg
	import pbmig_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output phase_t             carrier_step,
	output logic [MASK_W-1:0]  visible_mask,
	output phase_t             doppler_step [STEP_REGS],
	output logic [PDATA_W-1:0] offset_words
);

	phase_t             carrier_step_q;
	logic [MASK_W-1:0]  visible_mask_q;
	phase_t             doppler_step_q [STEP_REGS];
	logic [PDATA_W-1:0] offset_words_q;
	reg_idx_t           idx;
	logic               wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1 -: REG_IDX_W]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_step_q <= '0;
			visible_mask_q <= '0;
			offset_words_q <= '0;
			for (int i = 0; i < STEP_REGS; i++) begin
				doppler_step_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (idx)
				REG_CARRIER_STEP: carrier_step_q    <= pwdata[PHASE_W-1:0];
				REG_VISIBLE_MASK: visible_mask_q    <= pwdata[MASK_W-1:0];
				REG_DOPPLER_0:    doppler_step_q[0] <= pwdata[PHASE_W-1:0];
				REG_DOPPLER_1:    doppler_step_q[1] <= pwdata[PHASE_W-1:0];
				REG_DOPPLER_2:    doppler_step_q[2] <= pwdata[PHASE_W-1:0];
				REG_DOPPLER_3:    doppler_step_q[3] <= pwdata[PHASE_W-1:0];
				REG_OFFSET_WORDS: offset_words_q    <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CARRIER_STEP: prdata = PDATA_W'(carrier_step_q);
			REG_VISIBLE_MASK: prdata = PDATA_W'(visible_mask_q);
			REG_DOPPLER_0:    prdata = PDATA_W'(doppler_step_q[0]);
			REG_DOPPLER_1:    prdata = PDATA_W'(doppler_step_q[1]);
			REG_DOPPLER_2:    prdata = PDATA_W'(doppler_step_q[2]);
			REG_DOPPLER_3:    prdata = PDATA_W'(doppler_step_q[3]);
			REG_OFFSET_WORDS: prdata = offset_words_q;
			default:          prdata = '0;
		endcase
	end

	assign carrier_step = carrier_step_q;
	assign visible_mask = visible_mask_q;
	assign doppler_step = doppler_step_q;
	assign offset_words = offset_words_q;

endmodule

/* rtl/pbmig_ctrl.sv */
// Sequencing state machine: accepts a tick, walks the channels, settles, finishes.
// Depends on pbmig_pkg and the assertion macro header.
`include "prn_bpsk_and_multitone_iq_generator_unit_defines.svh"
module pbmig_ctrl
	import pbmig_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ISSUE  = 4'b0010,
		ST_SETTLE = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.start  = in_valid && in_ready;
	assign cmd.issue  = (state_q == ST_ISSUE);
	assign cmd.finish = (state_q == ST_FINISH) && status.out_free;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (status.last_ch) begin
					state_nxt = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`PBMIG_ASSERT_NEXT(a_start_issues, clk, arst_n, cmd.start, state_q == ST_ISSUE)
	`PBMIG_ASSERT_NEXT(a_last_ch_settles, clk, arst_n, cmd.issue && status.last_ch, state_q == ST_SETTLE)
	`PBMIG_ASSERT_NEXT(a_finish_waits, clk, arst_n, (state_q == ST_FINISH) && !status.out_free, state_q == ST_FINISH)
	`PBMIG_ASSERT_SAME(a_idle_quiet, clk, arst_n, in_ready, !cmd.issue && !cmd.finish)

endmodule

/* rtl/pbmig_dpath.sv */
// Datapath: phase accumulators, LFSR, shared sine table, I/Q accumulation and
// the output register. Depends on pbmig_pkg and pbmig_rom.
module pbmig_dpath
	import pbmig_pkg::*;
#(
	parameter int unsigned CHANNELS   = CHANNELS_DEF,
	parameter int unsigned TABLE_BITS = TABLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_status_t                 status,
	input  logic                       restart,
	input  logic                       final_tick,
	input  phase_t                     carrier_step,
	input  logic [MASK_W-1:0]          visible_mask,
	input  phase_t                     doppler_step [STEP_REGS],
	input  logic [PDATA_W-1:0]         offset_words,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] i_sample,
	output logic signed [SAMPLE_W-1:0] q_sample,
	output logic                       last
);

	localparam int unsigned ACT_CH = (CHANNELS < STEP_REGS) ? CHANNELS : STEP_REGS;
	localparam int unsigned CH_W   = (ACT_CH > 1) ? $clog2(ACT_CH) : 1;
	localparam int unsigned ADDR_W = TABLE_BITS + 1;
	localparam int unsigned K_W    = TABLE_BITS + 2;
	localparam logic [ADDR_W-1:0] N_FULL  = ADDR_W'(1) << TABLE_BITS;
	localparam logic [CH_W-1:0]   LAST_CH = CH_W'(ACT_CH - 1);

	phase_t                  carrier_q;
	phase_t                  dop_q [ACT_CH];
	logic [LFSR_W-1:0]       lfsr_q;
	logic [CH_W-1:0]         ch_q;
	logic                    lfsr_mode_q;
	logic                    en_s1;
	logic                    neg_c_s1;
	logic                    neg_s_s1;
	logic                    last_q;
	logic signed [ACC_W-1:0] iacc_q;
	logic signed [ACC_W-1:0] qacc_q;
	logic                    out_valid_q;
	logic [SAMPLE_W-1:0]     i_q;
	logic [SAMPLE_W-1:0]     q_q;
	logic                    last_out_q;

	logic [OFFSET_W-1:0]     off_w [ACT_CH];
	logic [ACT_CH-1:0]       active;
	phase_t                  ph_sum;
	logic [K_W-1:0]          k;
	logic [1:0]              quad_s;
	logic [1:0]              quad_c;
	logic [ADDR_W-1:0]       m_ext;
	logic [ADDR_W-1:0]       addr_s;
	logic [ADDR_W-1:0]       addr_c;
	logic                    chip;
	logic                    flip;
	logic                    en;
	logic [AMP_W-1:0]        rom_c;
	logic [AMP_W-1:0]        rom_s;
	logic signed [ACC_W-1:0] mag_c;
	logic signed [ACC_W-1:0] mag_s;
	logic signed [ACC_W-1:0] term_c;
	logic signed [ACC_W-1:0] term_s;

	for (genvar c = 0; c < ACT_CH; c++) begin : g_off
		assign off_w[c] = offset_words[c*OFFSET_W +: OFFSET_W];
	end

	assign active = visible_mask[ACT_CH-1:0];
	assign chip   = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
	assign flip   = lfsr_mode_q && !chip;
	assign en     = lfsr_mode_q ? (ch_q == '0) : active[ch_q];

	always_comb begin
		if (lfsr_mode_q) begin
			ph_sum = carrier_q;
		end else begin
			ph_sum = carrier_q + dop_q[ch_q] + {off_w[ch_q], {(PHASE_W-OFFSET_W){1'b0}}};
		end
	end

	// The cosine phase is a quarter turn ahead, so only the quadrant moves.
	assign k      = ph_sum[PHASE_W-1 -: K_W];
	assign quad_s = k[K_W-1 -: 2];
	assign quad_c = quad_s + 2'd1;
	assign m_ext  = {1'b0, k[TABLE_BITS-1:0]};
	assign addr_s = quad_s[0] ? (N_FULL - m_ext) : m_ext;
	assign addr_c = quad_c[0] ? (N_FULL - m_ext) : m_ext;

	pbmig_rom #(
		.TABLE_BITS (TABLE_BITS)
	) u_rom (
		.clk    (clk),
		.addr_a (addr_c),
		.addr_b (addr_s),
		.data_a (rom_c),
		.data_b (rom_s)
	);

	assign mag_c  = $signed(ACC_W'(rom_c));
	assign mag_s  = $signed(ACC_W'(rom_s));
	assign term_c = neg_c_s1 ? -mag_c : mag_c;
	assign term_s = neg_s_s1 ? -mag_s : mag_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q   <= '0;
			lfsr_q      <= LFSR_SEED;
			ch_q        <= '0;
			lfsr_mode_q <= 1'b0;
			en_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ACT_CH; i++) begin
				dop_q[i] <= '0;
			end
		end else begin
			en_s1 <= cmd.issue && en;
			if (cmd.start) begin
				ch_q        <= '0;
				lfsr_mode_q <= (active == '0);
				if (restart) begin
					carrier_q <= '0;
					lfsr_q    <= LFSR_SEED;
					for (int i = 0; i < ACT_CH; i++) begin
						dop_q[i] <= '0;
					end
				end
			end else if (cmd.finish) begin
				carrier_q <= carrier_q + carrier_step;
				for (int i = 0; i < ACT_CH; i++) begin
					dop_q[i] <= dop_q[i] + doppler_step[i];
				end
				if (lfsr_mode_q) begin
					lfsr_q <= {chip, lfsr_q[LFSR_W-1:1]};
				end
			end
			if (cmd.issue) begin
				ch_q <= ch_q + CH_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		neg_c_s1 <= quad_c[1] ^ flip;
		neg_s_s1 <= quad_s[1] ^ flip;
		if (cmd.start) begin
			last_q <= final_tick;
			iacc_q <= '0;
			qacc_q <= '0;
		end else if (en_s1) begin
			iacc_q <= iacc_q + term_c;
			qacc_q <= qacc_q + term_s;
		end
		if (cmd.finish) begin
			last_out_q <= last_q;
			if (lfsr_mode_q) begin
				i_q <= iacc_q[SAMPLE_W-1:0];
				q_q <= qacc_q[SAMPLE_W-1:0];
			end else begin
				i_q <= halve_sat(iacc_q);
				q_q <= halve_sat(qacc_q);
			end
		end
	end

	assign status.last_ch  = (ch_q == LAST_CH);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign i_sample  = $signed(i_q);
	assign q_sample  = $signed(q_q);
	assign last      = last_out_q;

endmodule

/* tb/tb_prn_bpsk_and_multitone_iq_generator_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the PRN BPSK and multi-tone I/Q generator.
// Depends on pbmig_pkg, the pbmig_if channel interfaces and the generator's RTL.
module tb_prn_bpsk_and_multitone_iq_generator_unit;
	import pbmig_pkg::*;

	localparam int unsigned TONE_BITS          = TABLE_BITS_DEF;
	localparam int unsigned QUARTER_POINTS     = 1 << TONE_BITS;
	localparam int unsigned LIVE_CHANNELS      = (CHANNELS_DEF < 4) ? CHANNELS_DEF : 4;
	localparam int unsigned REG_STRIDE         = 8;
	localparam int unsigned UNMAPPED_REG_IDX   = 7;
	localparam int unsigned SETTLE_CYCLES      = 12;
	localparam int unsigned HOLD_OFF_CYCLES    = 150;
	localparam int unsigned WATCHDOG_LIMIT     = 3000;
	localparam int unsigned PHASES_PER_SECTION = 6;
	localparam int unsigned TICKS_PER_PHASE    = 42;
	localparam int          SAT_LIMIT          = 32768;
	localparam logic [15:0] CHIP_SEED          = 16'hACE1;
	localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
	localparam bit [63:0]   UNITY_Q30          = 64'd1 << 30;
	localparam bit [63:0]   PI_HALF_Q30        = 64'd1686629713;

	typedef struct {
		logic signed [SAMPLE_W-1:0] i_val;
		logic signed [SAMPLE_W-1:0] q_val;
		logic                       last;
	} iq_sample_t;

	class iq_sample_board;
		bit [31:0]  carrier_step;
		bit [3:0]   visible_mask;
		bit [31:0]  doppler_step [4];
		bit [63:0]  offset_words;
		bit [15:0]  chip_lfsr;
		bit [31:0]  carrier_phase;
		bit [31:0]  doppler_phase [4];
		int         amp_table [0:QUARTER_POINTS];
		iq_sample_t expected_samples [$];
		int unsigned failures;
		int unsigned checked_count;
		int unsigned bpsk_count;
		int unsigned composite_count;

		function new();
			bit [63:0] x;
			bit [63:0] a;
			bit [63:0] a2;
			bit [63:0] t;
			bit [63:0] s;
			for (int unsigned m = 0; m <= QUARTER_POINTS; m++) begin
				x  = 64'(m) << (30 - TONE_BITS);
				a  = (x * PI_HALF_Q30) >> 30;
				a2 = (a * a) >> 30;
				t  = UNITY_Q30 - a2 / 64'd110;
				t  = UNITY_Q30 - ((a2 * t) >> 30) / 64'd72;
				t  = UNITY_Q30 - ((a2 * t) >> 30) / 64'd42;
				t  = UNITY_Q30 - ((a2 * t) >> 30) / 64'd20;
				t  = UNITY_Q30 - ((a2 * t) >> 30) / 64'd6;
				s  = (a * t) >> 30;
				s  = (s + (64'd1 << 15)) >> 16;
				if (s > 64'd16384) begin
					s = 64'd16384;
				end
				amp_table[m] = int'(s);
			end
			carrier_step  = '0;
			visible_mask  = '0;
			offset_words  = '0;
			chip_lfsr     = CHIP_SEED;
			carrier_phase = '0;
			foreach (doppler_step[c]) begin
				doppler_step[c]  = '0;
				doppler_phase[c] = '0;
			end
		endfunction

		function void write_reg(int unsigned idx, bit [63:0] value);
			case (idx)
				REG_CARRIER_STEP: carrier_step = value[31:0];
				REG_VISIBLE_MASK: visible_mask = value[3:0];
				REG_DOPPLER_0, REG_DOPPLER_1, REG_DOPPLER_2, REG_DOPPLER_3: begin
					doppler_step[idx - REG_DOPPLER_0] = value[31:0];
				end
				REG_OFFSET_WORDS: offset_words = value;
				default: ;
			endcase
		endfunction

		function int tone(bit [31:0] ph);
			bit [TONE_BITS-1:0] m;
			int mag;
			m   = ph[29 -: TONE_BITS];
			mag = ph[30] ? amp_table[QUARTER_POINTS - m] : amp_table[m];
			return ph[31] ? -mag : mag;
		endfunction

		function int halve_round(int acc);
			int h;
			h = (acc + 1) >>> 1;
			if (h > SAT_LIMIT) begin
				h = SAT_LIMIT;
			end
			if (h < -SAT_LIMIT) begin
				h = -SAT_LIMIT;
			end
			return h;
		endfunction

		function void note_tick(logic restart, logic fin);
			iq_sample_t want;
			bit [3:0]  live;
			bit [31:0] ph;
			bit        fb;
			int        i_acc;
			int        q_acc;
			if (restart) begin
				carrier_phase = '0;
				foreach (doppler_phase[c]) begin
					doppler_phase[c] = '0;
				end
				chip_lfsr = CHIP_SEED;
			end
			live = '0;
			for (int c = 0; c < LIVE_CHANNELS; c++) begin
				live[c] = visible_mask[c];
			end
			if (live == '0) begin
				fb        = chip_lfsr[0] ^ chip_lfsr[2] ^ chip_lfsr[3] ^ chip_lfsr[5];
				i_acc     = tone(carrier_phase + QUARTER_TURN);
				q_acc     = tone(carrier_phase);
				chip_lfsr = {fb, chip_lfsr[15:1]};
				if (!fb) begin
					i_acc = -i_acc;
					q_acc = -q_acc;
				end
				bpsk_count++;
			end else begin
				i_acc = 0;
				q_acc = 0;
				for (int c = 0; c < LIVE_CHANNELS; c++) begin
					if (live[c]) begin
						ph    = carrier_phase + doppler_phase[c]
							+ {offset_words[16*c +: 16], 16'h0000};
						i_acc += tone(ph + QUARTER_TURN);
						q_acc += tone(ph);
					end
				end
				i_acc = halve_round(i_acc);
				q_acc = halve_round(q_acc);
				composite_count++;
			end
			carrier_phase += carrier_step;
			foreach (doppler_phase[c]) begin
				doppler_phase[c] += doppler_step[c];
			end
			want.i_val = i_acc[SAMPLE_W-1:0];
			want.q_val = q_acc[SAMPLE_W-1:0];
			want.last  = fin;
			expected_samples.insert(expected_samples.size(), want);
		endfunction

		function void check_sample(logic signed [SAMPLE_W-1:0] i_got,
			logic signed [SAMPLE_W-1:0] q_got, logic last_got);
			iq_sample_t want;
			if (expected_samples.size() == 0) begin
				$error("Unexpected sample: i_sample=%0d q_sample=%0d last=%0b",
					i_got, q_got, last_got);
				failures++;
				return;
			end
			want = expected_samples.pop_front();
			checked_count++;
			if (i_got !== want.i_val) begin
				$error("i_sample: expected %0d, got %0d", want.i_val, i_got);
				failures++;
			end
			if (q_got !== want.q_val) begin
				$error("q_sample: expected %0d, got %0d", want.q_val, q_got);
				failures++;
			end
			if (last_got !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, last_got);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_samples.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pbmig_tick_if   tick_ch ();
	pbmig_sample_if sample_ch ();

	iq_sample_board iq_board;
	int unsigned    tx_idle_pct;
	int unsigned    rx_idle_pct;
	int unsigned    hold_requests;
	int unsigned    holds_served;
	int unsigned    ticks_sent;
	int unsigned    settings_applied;
	int unsigned    quiet_cycles;

	prn_bpsk_and_multitone_iq_generator_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.sample  (sample_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sample_ch.ready = 1'b0;
		holds_served    = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				sample_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			sample_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready) begin
				iq_board.note_tick(tick_ch.restart, tick_ch.final_tick);
			end
			if (sample_ch.valid && sample_ch.ready) begin
				iq_board.check_sample(sample_ch.i_sample, sample_ch.q_sample, sample_ch.last);
			end
			if ((tick_ch.valid && tick_ch.ready) || (sample_ch.valid && sample_ch.ready)
				|| (psel && penable && pready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired after %0d cycles without a transaction.",
					quiet_cycles);
				$display("** prn_bpsk_and_multitone_iq_generator_unit: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_tick(input logic restart, input logic fin);
		while ($urandom_range(99) < tx_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid      <= 1'b1;
		tick_ch.restart    <= restart;
		tick_ch.final_tick <= fin;
		do @(posedge clk); while (!tick_ch.ready);
		ticks_sent++;
	endtask

	task automatic send_burst(input int unsigned len);
		for (int unsigned k = 0; k < len; k++) begin
			send_tick(k == 0, k == len - 1);
		end
	endtask

	task automatic wait_idle();
		tick_ch.valid <= 1'b0;
		do @(posedge clk); while (iq_board.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input int unsigned idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * REG_STRIDE);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		iq_board.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [63:0] carrier_word, input logic [63:0] mask_word,
		input logic [63:0] d0, input logic [63:0] d1, input logic [63:0] d2,
		input logic [63:0] d3, input logic [63:0] offs);
		wait_idle();
		apb_write(REG_CARRIER_STEP, carrier_word);
		apb_write(REG_VISIBLE_MASK, mask_word);
		apb_write(REG_DOPPLER_0, d0);
		apb_write(REG_DOPPLER_1, d1);
		apb_write(REG_DOPPLER_2, d2);
		apb_write(REG_DOPPLER_3, d3);
		apb_write(REG_OFFSET_WORDS, offs);
		apb_write(UNMAPPED_REG_IDX, {$urandom, $urandom});
		settings_applied++;
	endtask

	function automatic logic [63:0] step_word();
		logic [31:0] step;
		case ($urandom_range(5))
			0: step = '0;
			1: step = '1;
			2: step = 32'h8000_0000;
			3: step = 32'd1;
			default: step = $urandom;
		endcase
		return {$urandom, step};
	endfunction

	function automatic logic [63:0] offset_word();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return 64'h8000_4000_C000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic randomise_settings();
		logic [63:0] mask_word;
		mask_word = {$urandom, $urandom};
		if ($urandom_range(2) == 0) begin
			mask_word[3:0] = '0;
		end
		apply_settings(step_word(), mask_word, step_word(), step_word(), step_word(),
			step_word(), offset_word());
	endtask

	task automatic random_section(input int unsigned tx_pct, input int unsigned rx_pct);
		int unsigned target;
		rx_idle_pct <= rx_pct;
		for (int p = 0; p < PHASES_PER_SECTION; p++) begin
			randomise_settings();
			tx_idle_pct = tx_pct;
			if (p == 1) begin
				// The sink is held off while ticks keep coming, so the block backs up.
				tx_idle_pct = 0;
				hold_requests <= hold_requests + 1;
			end
			target = ticks_sent + TICKS_PER_PHASE;
			while (ticks_sent < target) begin
				if ($urandom_range(99) < 85) begin
					send_burst($urandom_range(1, 24));
				end else begin
					repeat ($urandom_range(1, 5)) begin
						send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
					end
				end
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		tick_ch.valid      = 1'b0;
		tick_ch.restart    = 1'b0;
		tick_ch.final_tick = 1'b0;
		tx_idle_pct        = 37;
		rx_idle_pct        = 72;
		hold_requests      = 0;
		ticks_sent         = 0;
		settings_applied   = 0;
		quiet_cycles       = 0;
		iq_board           = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset settings: chips at zero phase, every combination of restart and last.
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		// Quarter-turn carrier steps land on the quadrant boundaries.
		apply_settings(64'h4000_0000, '0, '0, '0, '0, '0, '0);
		send_burst(4);
		// All registers at their maximum, with every accumulator wrapping.
		apply_settings('1, '1, '1, '1, '1, '1, '1);
		send_burst(4);
		// All four tones in phase give the largest positive composite sum.
		apply_settings('0, 64'hF, '0, '0, '0, '0, '0);
		send_burst(2);
		// All four tones at half a turn give the largest negative sum.
		apply_settings('0, 64'hF, '0, '0, '0, '0, 64'h8000_8000_8000_8000);
		send_burst(2);
		// A single tone exercises rounding of odd sums when halved.
		apply_settings(64'h0123_4567, 64'h1, 64'h0765_4321, '0, '0, '0, 64'h1555);
		send_burst(4);
		// Mask bits above the channels are ignored, so this stays in chip mode.
		apply_settings(64'h8000_0000, 64'hFFFF_FFFF_FFFF_FFF0, '1, '1, '1, '1, '1);
		send_burst(2);

		random_section(37, 72);
		random_section(72, 37);
		random_section(0, 0);

		wait_idle();
		$display("Checked %0d samples from %0d ticks under %0d register settings.",
			iq_board.checked_count, ticks_sent, settings_applied);
		$display("Chip-mode samples: %0d, composite samples: %0d, long sink hold-offs: %0d.",
			iq_board.bpsk_count, iq_board.composite_count, holds_served);
		if (iq_board.failures == 0) begin
			$display("** prn_bpsk_and_multitone_iq_generator_unit: PASSED **");
		end else begin
			$display("** prn_bpsk_and_multitone_iq_generator_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/pbmig_pkg.sv
rtl/pbmig_if.sv
rtl/pbmig_rom.sv
rtl/pbmig_cfg.sv
rtl/pbmig_ctrl.sv
rtl/pbmig_dpath.sv
rtl/prn_bpsk_and_multitone_iq_generator_unit.sv
tb/tb_prn_bpsk_and_multitone_iq_generator_unit.sv
